// ===== hdl/fcx_pkg.sv =====
// ---------------------------------------------------------------------------
// fcx_pkg - shared types and codes for the four-operand execute stage
// Opcodes, status codes, fixed field widths and the ALU result bundle.
// ---------------------------------------------------------------------------
package fcx_pkg;

  localparam int DATA_W  = 32;
  localparam int KIND_W  = 8;
  localparam int IDX_W   = 4;
  localparam int STAT_W  = 2;

  // opcodes
  localparam logic [KIND_W-1:0] OP_ADD  = 8'd0;
  localparam logic [KIND_W-1:0] OP_SUB  = 8'd1;
  localparam logic [KIND_W-1:0] OP_MAC  = 8'd2;
  localparam logic [KIND_W-1:0] OP_AND  = 8'd3;
  localparam logic [KIND_W-1:0] OP_OR   = 8'd4;
  localparam logic [KIND_W-1:0] OP_XOR  = 8'd5;
  localparam logic [KIND_W-1:0] OP_SLL  = 8'd6;
  localparam logic [KIND_W-1:0] OP_SRA  = 8'd7;
  localparam logic [KIND_W-1:0] OP_SRL  = 8'd8;
  localparam logic [KIND_W-1:0] OP_BEQ  = 8'd9;
  localparam logic [KIND_W-1:0] OP_BNE  = 8'd10;
  localparam logic [KIND_W-1:0] OP_BLT  = 8'd11;
  localparam logic [KIND_W-1:0] OP_BGT  = 8'd12;
  localparam logic [KIND_W-1:0] OP_BLE  = 8'd13;
  localparam logic [KIND_W-1:0] OP_BGE  = 8'd14;
  localparam logic [KIND_W-1:0] OP_JAL  = 8'd15;
  localparam logic [KIND_W-1:0] OP_LW   = 8'd16;
  localparam logic [KIND_W-1:0] OP_SW   = 8'd17;
  localparam logic [KIND_W-1:0] OP_RETI = 8'd18;
  localparam logic [KIND_W-1:0] OP_IN   = 8'd19;
  localparam logic [KIND_W-1:0] OP_OUT  = 8'd20;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_MEM = 2'd1;
  localparam logic [STAT_W-1:0] ST_IO  = 2'd2;

  // I/O word holding the interrupt return address
  localparam int RETURN_SLOT = 7;

  typedef struct packed {
    logic [DATA_W-1:0] val;       // result of non-multiply ALU ops
    logic [DATA_W-1:0] prod;      // low word of rs*rt
    logic              take;      // branch condition true
    logic              has_dest;  // op writes rd from val/prod
  } alu_res_t;

endpackage

// ===== hdl/four_operand_cpu_execute_stage_core.sv =====
// ---------------------------------------------------------------------------
// four_operand_cpu_execute_stage_core - execute stage of a small RISC core
// Runs one decoded instruction against the register file, data memory and
// I/O registers, and reports next pc, status and the destination write.
//
//   channel  dir  handshake           payload
//   in_      in   in_tvalid/tready    tdata: rd,rs,rt,rm,pc   tuser: kind
//   out_     out  out_tvalid/tready   tdata: next_pc,status,isr_exit,
//                                            dest_written,dest_value
//
// One instruction at a time: rs/rt read, rm/rd read, execute with data
// memory or I/O read, then write-back, all through the synchronous
// register file and memories; no new instruction is taken before
// write-back. The result waits in an output register; write-back stalls
// only while that register is still full. After reset a clearing pass
// zeroes all stores; in_tready stays low until it is done.
// ---------------------------------------------------------------------------
module four_operand_cpu_execute_stage_core #(
  parameter int REG_COUNT = 16,
  parameter int MEM_DEPTH = 4096,
  parameter int IO_COUNT  = 32,
  parameter int PC_WIDTH  = 12,
  localparam int IN_W  = ((4 * fcx_pkg::IDX_W + PC_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((PC_WIDTH + fcx_pkg::STAT_W + 2 + fcx_pkg::DATA_W + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [IN_W-1:0]            in_tdata,   // rd_index, rs_index, rt_index, rm_index, pc
  input  logic [fcx_pkg::KIND_W-1:0] in_tuser,   // kind
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [OUT_W-1:0]           out_tdata   // next_pc, status, isr_exit, dest_written,
                                                 // dest_value
);
  import fcx_pkg::*;

  localparam int RW  = $clog2(REG_COUNT);
  localparam int MW  = $clog2(MEM_DEPTH);
  localparam int IOW = $clog2(IO_COUNT);
  localparam int PW  = PC_WIDTH;
  localparam int PAY_W = PW + STAT_W + 2 + DATA_W;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_EXE  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [MW-1:0]     clr_r, clr_nxt;

  logic [KIND_W-1:0] kind_r;
  logic [IDX_W-1:0]  rd_r, rs_r, rt_r, rm_r;
  logic [PW-1:0]     pc_r;
  logic [DATA_W-1:0] a_r, b_r, c_r, d_r;
  alu_res_t          alu_r;
  logic [STAT_W-1:0] status_r;
  logic [MW-1:0]     maddr_r;
  logic [IOW-1:0]    ioaddr_r;

  logic              out_tvalid_r;
  logic [OUT_W-1:0]  out_tdata_r;

  // input unpack
  logic [IDX_W-1:0]  in_rd, in_rs, in_rt, in_rm;
  logic [PW-1:0]     in_pc;
  logic              accept;

  assign in_rd  = in_tdata[IDX_W-1:0];
  assign in_rs  = in_tdata[2*IDX_W-1:IDX_W];
  assign in_rt  = in_tdata[3*IDX_W-1:2*IDX_W];
  assign in_rm  = in_tdata[4*IDX_W-1:3*IDX_W];
  assign in_pc  = in_tdata[4*IDX_W+PW-1:4*IDX_W];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // register index usable: nonzero and inside the file
  logic rs_ok, rt_ok, rm_ok, rd_ok;
  assign rs_ok = (rs_r != '0) && (32'(rs_r) < 32'(REG_COUNT));
  assign rt_ok = (rt_r != '0) && (32'(rt_r) < 32'(REG_COUNT));
  assign rm_ok = (rm_r != '0) && (32'(rm_r) < 32'(REG_COUNT));
  assign rd_ok = (rd_r != '0) && (32'(rd_r) < 32'(REG_COUNT));

  // ---- register file ----
  logic              rf_we, rf_re;
  logic [RW-1:0]     rf_waddr, rf_raddr_a, rf_raddr_b;
  logic [DATA_W-1:0] rf_wdata, rf_rdata_a, rf_rdata_b;

  fcx_regfile #(.COUNT(REG_COUNT)) u_regfile (
    .clk     (clk),
    .we      (rf_we),
    .waddr   (rf_waddr),
    .wdata   (rf_wdata),
    .re      (rf_re),
    .raddr_a (rf_raddr_a),
    .raddr_b (rf_raddr_b),
    .rdata_a (rf_rdata_a),
    .rdata_b (rf_rdata_b)
  );

  // ---- data memory and I/O registers ----
  logic              dm_we, dm_re;
  logic [MW-1:0]     dm_waddr, dm_raddr;
  logic [DATA_W-1:0] dm_wdata, dm_rdata;
  logic              io_we, io_re;
  logic [IOW-1:0]    io_waddr, io_raddr;
  logic [DATA_W-1:0] io_wdata, io_rdata;

  fcx_ram #(.DEPTH(MEM_DEPTH), .WIDTH(DATA_W)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (dm_re),
    .raddr (dm_raddr),
    .rdata (dm_rdata)
  );

  fcx_ram #(.DEPTH(IO_COUNT), .WIDTH(DATA_W)) u_io (
    .clk   (clk),
    .we    (io_we),
    .waddr (io_waddr),
    .wdata (io_wdata),
    .re    (io_re),
    .raddr (io_raddr),
    .rdata (io_rdata)
  );

  // ---- execute cycle ----
  logic [DATA_W-1:0] c_cur, d_cur;
  logic [DATA_W-1:0] sum_ab, sum_abc, maddr_full;
  logic              mem_in, io_in;
  logic [STAT_W-1:0] status_cur;
  alu_res_t          alu_res;

  assign c_cur      = rm_ok ? rf_rdata_a : '0;
  assign d_cur      = rd_ok ? rf_rdata_b : '0;
  assign sum_ab     = a_r + b_r;
  assign sum_abc    = sum_ab + c_cur;
  assign maddr_full = (kind_r == OP_LW) ? sum_abc : sum_ab;
  assign mem_in     = !maddr_full[DATA_W-1] && (maddr_full < 32'(MEM_DEPTH));
  assign io_in      = !sum_ab[DATA_W-1] && (sum_ab < 32'(IO_COUNT));

  always_comb begin
    status_cur = ST_OK;
    case (kind_r)
      OP_LW, OP_SW:  status_cur = mem_in ? ST_OK : ST_MEM;
      OP_IN, OP_OUT: status_cur = io_in ? ST_OK : ST_IO;
      default:       status_cur = ST_OK;
    endcase
  end

  fcx_alu u_alu (
    .kind (kind_r),
    .a    (a_r),
    .b    (b_r),
    .c    (c_cur),
    .res  (alu_res)
  );

  // ---- write-back cycle ----
  logic              out_free, commit;
  logic [DATA_W-1:0] link, wb_val;
  logic              wb_dest, wrote;
  logic [PW-1:0]     next_pc;
  logic              isr_exit;
  logic [PAY_W-1:0]  payload;

  assign out_free = !out_tvalid_r || out_tready;
  assign commit   = (state_r == S_WB) && out_free;
  assign link     = DATA_W'(pc_r) + 1'b1;

  always_comb begin
    wb_val  = alu_r.val;
    wb_dest = alu_r.has_dest;
    case (kind_r)
      OP_MAC: wb_val = alu_r.prod + c_r;
      OP_LW:  begin wb_val = dm_rdata; wb_dest = (status_r == ST_OK); end
      OP_IN:  begin wb_val = io_rdata; wb_dest = (status_r == ST_OK); end
      OP_JAL: begin wb_val = link;     wb_dest = 1'b1; end
      default: ;
    endcase
  end

  assign wrote    = wb_dest && rd_ok;
  assign isr_exit = (kind_r == OP_RETI);

  always_comb begin
    next_pc = pc_r + 1'b1;
    if (alu_r.take) begin
      next_pc = c_r[PW-1:0];
    end
    case (kind_r)
      // target read after the link write
      OP_JAL:  next_pc = (rm_r == rd_r && rd_ok) ? link[PW-1:0] : c_r[PW-1:0];
      OP_RETI: next_pc = io_rdata[PW-1:0];
      default: ;
    endcase
  end

  assign payload = {(wrote ? wb_val : {DATA_W{1'b0}}), wrote, isr_exit, status_r, next_pc};

  // ---- memory port control ----
  logic clearing;
  assign clearing = (state_r == S_CLR);

  always_comb begin
    rf_re      = accept || (state_r == S_RD2);
    rf_raddr_a = (state_r == S_RD2) ? RW'(rm_r) : RW'(in_rs);
    rf_raddr_b = (state_r == S_RD2) ? RW'(rd_r) : RW'(in_rt);
    rf_we      = clearing ? ({1'b0, clr_r} < (MW+1)'(REG_COUNT)) : (commit && wrote);
    rf_waddr   = clearing ? clr_r[RW-1:0] : RW'(rd_r);
    rf_wdata   = clearing ? '0 : wb_val;

    dm_re      = (state_r == S_EXE);
    dm_raddr   = maddr_full[MW-1:0];
    dm_we      = clearing || (commit && kind_r == OP_SW && status_r == ST_OK);
    dm_waddr   = clearing ? clr_r : maddr_r;
    dm_wdata   = clearing ? '0 : (d_r + c_r);

    io_re      = (state_r == S_EXE);
    io_raddr   = (kind_r == OP_RETI) ? IOW'(RETURN_SLOT) : sum_ab[IOW-1:0];
    io_we      = clearing ? ({1'b0, clr_r} < (MW+1)'(IO_COUNT))
                          : (commit && kind_r == OP_OUT && status_r == ST_OK);
    io_waddr   = clearing ? clr_r[IOW-1:0] : ioaddr_r;
    io_wdata   = clearing ? '0 : c_r;
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == MW'(MEM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: if (accept) state_nxt = S_RD2;
      S_RD2:  state_nxt = S_EXE;
      S_EXE:  state_nxt = S_WB;
      S_WB:   if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (commit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_tuser;
      rd_r   <= in_rd;
      rs_r   <= in_rs;
      rt_r   <= in_rt;
      rm_r   <= in_rm;
      pc_r   <= in_pc;
    end
    if (state_r == S_RD2) begin
      a_r <= rs_ok ? rf_rdata_a : '0;
      b_r <= rt_ok ? rf_rdata_b : '0;
    end
    if (state_r == S_EXE) begin
      c_r      <= c_cur;
      d_r      <= d_cur;
      alu_r    <= alu_res;
      status_r <= status_cur;
      maddr_r  <= maddr_full[MW-1:0];
      ioaddr_r <= sum_ab[IOW-1:0];
    end
    if (commit) begin
      out_tdata_r <= OUT_W'(payload);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== hdl/fcx_ram.sv =====
// ---------------------------------------------------------------------------
// fcx_ram - single-port-write, single-port-read synchronous memory
// Read data registered on read enable.
// ---------------------------------------------------------------------------
module fcx_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/fcx_regfile.sv =====
// ---------------------------------------------------------------------------
// fcx_regfile - register file, two synchronous read ports, one write port
// Both read ports share one enable; data holds between reads.
// ---------------------------------------------------------------------------
module fcx_regfile #(
  parameter int COUNT = 16,
  localparam int RW = $clog2(COUNT)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [RW-1:0]             waddr,
  input  logic [fcx_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [RW-1:0]             raddr_a,
  input  logic [RW-1:0]             raddr_b,
  output logic [fcx_pkg::DATA_W-1:0] rdata_a,
  output logic [fcx_pkg::DATA_W-1:0] rdata_b
);
  import fcx_pkg::*;

  logic [DATA_W-1:0] regs [COUNT];
  logic [DATA_W-1:0] rdata_a_r;
  logic [DATA_W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      regs[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= regs[raddr_a];
      rdata_b_r <= regs[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== hdl/fcx_alu.sv =====
// ---------------------------------------------------------------------------
// fcx_alu - three-input ALU, shifter, multiplier and branch compare
// Pure logic; the caller registers the result bundle.
// ---------------------------------------------------------------------------
module fcx_alu (
  input  logic [fcx_pkg::KIND_W-1:0] kind,
  input  logic [fcx_pkg::DATA_W-1:0] a,
  input  logic [fcx_pkg::DATA_W-1:0] b,
  input  logic [fcx_pkg::DATA_W-1:0] c,
  output fcx_pkg::alu_res_t          res
);
  import fcx_pkg::*;

  logic [4:0] sh;
  logic       lt_ab;
  logic       lt_ba;

  assign sh    = b[4:0];
  assign lt_ab = $signed(a) < $signed(b);
  assign lt_ba = $signed(b) < $signed(a);

  always_comb begin
    res.val      = '0;
    res.prod     = a * b;
    res.take     = 1'b0;
    res.has_dest = 1'b0;
    case (kind)
      OP_ADD: begin res.val = a + b + c;                    res.has_dest = 1'b1; end
      OP_SUB: begin res.val = a - b - c;                    res.has_dest = 1'b1; end
      OP_MAC: begin                                         res.has_dest = 1'b1; end
      OP_AND: begin res.val = a & b & c;                    res.has_dest = 1'b1; end
      OP_OR:  begin res.val = a | b | c;                    res.has_dest = 1'b1; end
      OP_XOR: begin res.val = a ^ b ^ c;                    res.has_dest = 1'b1; end
      OP_SLL: begin res.val = a << sh;                      res.has_dest = 1'b1; end
      OP_SRA: begin res.val = DATA_W'($signed(a) >>> sh);   res.has_dest = 1'b1; end
      OP_SRL: begin res.val = a >> sh;                      res.has_dest = 1'b1; end
      OP_BEQ: res.take = (a == b);
      OP_BNE: res.take = (a != b);
      OP_BLT: res.take = lt_ab;
      OP_BGT: res.take = lt_ba;
      OP_BLE: res.take = !lt_ba;
      OP_BGE: res.take = !lt_ab;
      default: ;
    endcase
  end

endmodule
